### rtl/aep_pkg.sv
package aep_pkg;

  // Character codes used by the parser
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_UX     = 8'h58;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LX     = 8'h78;

  localparam logic [4:0] HEX_NONE   = 5'd16;
  localparam logic [2:0] DEC_SAT    = 3'd5;
  localparam logic [2:0] LEN_DFLT   = 3'd1;
  localparam logic [2:0] LEN_MAX    = 3'd4;
  localparam int         FEED_STEPS = 4;

  typedef enum logic [7:0] {
    PH_SKIP  = 8'b0000_0001,
    PH_ZERO  = 8'b0000_0010,
    PH_HEX1  = 8'b0000_0100,
    PH_HEX2  = 8'b0000_1000,
    PH_BLANK = 8'b0001_0000,
    PH_DEC   = 8'b0010_0000,
    PH_OK    = 8'b0100_0000,
    PH_FAIL  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [23:0] first_acc;
    logic [15:0] second_acc;
    logic [2:0]  dec_acc;
    logic        seen_digit;
    logic        ended;
    logic        has_colon;
  } parse_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  bank;
    logic [15:0] addr;
    logic [2:0]  length;
  } result_t;

  localparam parse_t PARSE_RESET = '{
    phase: PH_SKIP, first_acc: 24'd0, second_acc: 16'd0, dec_acc: 3'd0,
    seen_digit: 1'b0, ended: 1'b0, has_colon: 1'b0
  };

  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] v;
    v = HEX_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) v = {1'b0, c[3:0]};
    else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF))
      v = {1'b0, c[3:0] + 4'd9};
    return v;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  // One character through the phase machine; a phase may hand the same
  // character on to the next one, at most twice.
  function automatic parse_t feed(parse_t s, logic [7:0] c);
    parse_t     r;
    logic       done;
    logic [4:0] d;
    logic [6:0] dn;
    r    = s;
    done = 1'b0;
    d    = hex_value(c);
    dn   = {1'b0, r.dec_acc, 3'b000} + {3'b000, r.dec_acc, 1'b0} + {3'b000, c[3:0]};
    for (int i = 0; i < FEED_STEPS; i++) begin
      if (!done) begin
        unique case (r.phase)
          PH_SKIP: begin
            if (is_blank(c)) done = 1'b1;
            else if (c == CH_DOLLAR) begin
              r.phase = PH_HEX1;
              done    = 1'b1;
            end else if (c == CH_ZERO) begin
              r.phase      = PH_ZERO;
              r.first_acc  = 24'd0;
              r.seen_digit = 1'b1;
              done         = 1'b1;
            end else r.phase = PH_HEX1;
          end
          PH_ZERO: begin
            if (c == CH_LX || c == CH_UX) begin
              r.seen_digit = 1'b0;
              r.phase      = PH_HEX1;
              done         = 1'b1;
            end else r.phase = PH_HEX1;
          end
          PH_HEX1: begin
            if (!d[4]) begin
              r.first_acc  = {r.first_acc[19:0], d[3:0]};
              r.seen_digit = 1'b1;
              done         = 1'b1;
            end else if (!r.seen_digit) begin
              r.phase = PH_FAIL;
              done    = 1'b1;
            end else if (c == CH_COLON) begin
              r.phase      = PH_HEX2;
              r.seen_digit = 1'b0;
              r.has_colon  = 1'b1;
              done         = 1'b1;
            end else r.phase = PH_BLANK;
          end
          PH_HEX2: begin
            if (!d[4]) begin
              r.second_acc = {r.second_acc[11:0], d[3:0]};
              r.seen_digit = 1'b1;
              done         = 1'b1;
            end else if (!r.seen_digit) begin
              r.phase = PH_FAIL;
              done    = 1'b1;
            end else r.phase = PH_BLANK;
          end
          PH_BLANK: begin
            if (c == CH_COMMA) begin
              r.phase   = PH_DEC;
              r.dec_acc = 3'd0;
            end else if (!is_blank(c)) r.phase = PH_OK;
            done = 1'b1;
          end
          PH_DEC: begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
              // a leading zero digit leaves dec_acc at zero for the next digit
              if (dn > {4'd0, DEC_SAT}) r.dec_acc = DEC_SAT;
              else r.dec_acc = dn[2:0];
            end else r.phase = PH_OK;
            done = 1'b1;
          end
          default: done = 1'b1;
        endcase
      end
    end
    return r;
  endfunction

endpackage

### rtl/aep_text_if.sv
interface aep_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

### rtl/aep_result_if.sv
interface aep_result_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [7:0]  bank;
  logic [15:0] addr;
  logic [2:0]  length;

  modport source (output valid, output ok, output bank, output addr, output length,
                  input ready);
  modport sink (input valid, input ok, input bank, input addr, input length,
                output ready);
endinterface

### rtl/aep_core.sv
module aep_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        ch,
  input  logic              last,
  output aep_pkg::result_t  result
);

  aep_pkg::parse_t st;
  aep_pkg::parse_t st_next;
  aep_pkg::parse_t closed;

  always_comb begin
    st_next = st;
    if (!st.ended) begin
      st_next = aep_pkg::feed(st, ch);
      if (ch == aep_pkg::CH_NUL) st_next.ended = 1'b1;
    end
    // final character closes the text as if a zero byte followed
    closed = st_next.ended ? st_next : aep_pkg::feed(st_next, aep_pkg::CH_NUL);
  end

  always_comb begin
    if (closed.phase == aep_pkg::PH_OK) begin
      result.ok = 1'b1;
      if (closed.has_colon) begin
        result.bank = closed.first_acc[7:0];
        result.addr = closed.second_acc;
      end else begin
        result.bank = closed.first_acc[23:16];
        result.addr = closed.first_acc[15:0];
      end
      result.length = (closed.dec_acc >= aep_pkg::LEN_DFLT &&
                       closed.dec_acc <= aep_pkg::LEN_MAX) ?
                      closed.dec_acc : aep_pkg::LEN_DFLT;
    end else begin
      result.ok     = 1'b0;
      result.bank   = 8'd0;
      result.addr   = 16'd0;
      result.length = aep_pkg::LEN_DFLT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= aep_pkg::PARSE_RESET;
    end else if (accept) begin
      st <= last ? aep_pkg::PARSE_RESET : st_next;
    end
  end

endmodule

### rtl/aep_skid.sv
module aep_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  aep_pkg::result_t  push_data,
  output logic              push_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output aep_pkg::result_t  out_data
);

  logic             skid_valid;
  aep_pkg::result_t skid_data;

  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

### rtl/address_expression_parser_unit.sv
// Address expression parser: reads text of the form [bank:]addr[,len], one
// character per request on the text channel, and returns one result per
// expression on the result channel.
//   text   : ch (8 bits) and last; last marks the final character. A zero
//            byte ends the text early and later characters are dropped.
//   result : ok, bank, addr, length; one request per expression, issued
//            for the request that carries last. Failure gives ok = 0,
//            zeros and length 1.
// The last character's result is registered, in the skid register if
// the receiver stalls. Throughput: one character per cycle while
// text.ready is high, set by the core's short shift-or / compare chain.
// The result sits in an output register backed by a one-entry skid
// register; text.ready is low only while that skid entry is occupied,
// i.e. after the receiver stalled with a result pending and another one
// arrived. Characters of the next expression keep flowing otherwise.
// Reset (rst, synchronous) returns the parser to leading-blank skip,
// clears all accumulators and empties both result registers.
module address_expression_parser_unit (
  input logic          clk,
  input logic          rst,
  aep_text_if.sink     text,
  aep_result_if.source result
);

  logic             accept;
  logic             push_ready;
  aep_pkg::result_t core_res;
  aep_pkg::result_t out_res;

  // characters are taken whenever the skid entry is free
  assign text.ready = push_ready;
  assign accept     = text.valid && push_ready;

  aep_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .ch     (text.ch),
    .last   (text.last),
    .result (core_res)
  );

  // only the final character of an expression produces a result
  aep_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push       (accept && text.last),
    .push_data  (core_res),
    .push_ready (push_ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_data   (out_res)
  );

  assign result.ok     = out_res.ok;
  assign result.bank   = out_res.bank;
  assign result.addr   = out_res.addr;
  assign result.length = out_res.length;

endmodule

### rtl/aep_checker.sv
module aep_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        ok,
  input logic [7:0]  bank,
  input logic [15:0] addr,
  input logic [2:0]  length
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({ok, bank, addr, length}))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> bank == 8'd0 && addr == 16'd0 && length == 3'd1)
    else $error("failed parse carries nonzero fields");

  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> length >= 3'd1 && length <= 3'd4)
    else $error("length out of range");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("result pending after reset");

  // text only stalls behind a stalled result
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("text stalled without result backpressure");

endmodule

bind address_expression_parser_unit aep_checker u_aep_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (text.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .ok        (result.ok),
  .bank      (result.bank),
  .addr      (result.addr),
  .length    (result.length)
);
